// ===== rtl/sau_pkg.sv =====
// Shared types, constants and the sigmoid table of the sigmoid activation unit.
package sau_pkg;

    // Table geometry: entry k holds round(4096 * sigmoid(8*k/TABLE_SEGMENTS))
    localparam int TABLE_SEGMENTS = 128;
    localparam int SEG_W          = $clog2(TABLE_SEGMENTS);
    localparam int ROM_AW         = $clog2(TABLE_SEGMENTS + 1);

    // Fixed Q4.12 field widths
    localparam int ACT_W   = 16;
    localparam int GRAD_W  = 16;
    localparam int VAL_W   = 14;
    localparam int MAG_W   = 15;               // |x| for every x except -8.0
    localparam int FRAC_W  = 15;               // fraction of a segment, 1/32768 units
    localparam int POS_W   = MAG_W + SEG_W;    // |x| * TABLE_SEGMENTS
    localparam int SIG_W   = 13;               // sigmoid in 0..4096
    localparam int DS_W    = 11;               // s*(1-s) in 0..1024
    localparam int FIX_ONE = 4096;
    localparam int VAL_MAX = 8191;
    localparam int VAL_MIN = -8192;

    // Decoupling queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Pass mode codes
    localparam logic MODE_FORWARD  = 1'b0;
    localparam logic MODE_BACKWARD = 1'b1;

    // One classified element on its way from front to back
    typedef struct packed {
        logic                     sat;    // x = -8.0, sigmoid is exactly 0
        logic                     neg;    // x < 0, mirror through 1 - s
        logic [SEG_W-1:0]         seg;
        logic [FRAC_W-1:0]        frac;
        logic signed [GRAD_W-1:0] grad;
        logic                     mode;
    } t_item;

    typedef logic [SIG_W-1:0] t_rom [0:TABLE_SEGMENTS];

    function automatic t_rom build_rom();
        t_rom tab;
        real  t;
        for (int k = 0; k <= TABLE_SEGMENTS; k++) begin
            t      = 8.0 * k / TABLE_SEGMENTS;
            // 1/(1+e^-t) written as exp(-ln(1+e^-t))
            tab[k] = SIG_W'($rtoi(4096.0 * $exp(-$ln(1.0 + $exp(-t))) + 0.5));
        end
        return tab;
    endfunction

    localparam t_rom SIG_ROM = build_rom();

endpackage

// ===== rtl/sau_front.sv =====
// Front end: configuration register, input capture and classification of each element.
module sau_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_wdata,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [sau_pkg::ACT_W-1:0]  i_activation_in,
    input  logic signed [sau_pkg::GRAD_W-1:0] i_grad_in,
    input  logic                              i_queue_full,
    output logic                              o_push,
    output sau_pkg::t_item                    o_item
);
    import sau_pkg::*;

    logic                    r_pass_mode;
    logic                    r_valid;
    t_item                   r_item;
    t_item                   n_item;
    logic                    accept;
    logic                    neg;
    logic [ACT_W-1:0]        abs_x;
    logic [POS_W-1:0]        pos;

    assign busy   = r_valid && i_queue_full;
    assign accept = start && !busy;
    assign o_push = r_valid && !i_queue_full;
    assign o_item = r_item;

    always_comb begin
        neg          = i_activation_in[ACT_W-1];
        abs_x        = neg ? ACT_W'(-i_activation_in) : ACT_W'(i_activation_in);
        pos          = POS_W'(abs_x[MAG_W-1:0]) * POS_W'(TABLE_SEGMENTS);
        n_item.sat   = (i_activation_in == {1'b1, {(ACT_W-1){1'b0}}});
        n_item.neg   = neg;
        n_item.seg   = pos[POS_W-1:FRAC_W];
        n_item.frac  = pos[FRAC_W-1:0];
        n_item.grad  = i_grad_in;
        n_item.mode  = r_pass_mode;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pass_mode <= MODE_FORWARD;
            r_valid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_pass_mode <= i_cfg_wdata;
            end
            if (accept) begin
                r_valid <= 1'b1;
            end else if (o_push) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
    end

    a_accept_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> r_valid)
        else $error("accepted element not held in front register");

    a_busy_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> r_valid && $stable(r_item))
        else $error("front register changed while stalled");

    a_sat_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_item.sat |-> r_item.neg)
        else $error("saturated element not marked negative");

endmodule

// ===== rtl/sau_queue.sv =====
// Short queue that decouples the front end from the arithmetic back end.
module sau_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  sau_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output sau_pkg::t_item o_item
);
    import sau_pkg::*;

    t_item              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;
    logic               do_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");

    a_pop_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_pop && !i_push && r_count == QCNT_W'(1) |=> !o_valid)
        else $error("queue not empty after last pop");

endmodule

// ===== rtl/sau_back.sv =====
// Back end: table interpolation, sigmoid mirroring and the derivative product pipeline.
module sau_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  sau_pkg::t_item                   i_item,
    output logic                             o_pop,
    output logic                             o_valid,
    output logic signed [sau_pkg::VAL_W-1:0] o_value_out
);
    import sau_pkg::*;

    // Stage 1: table reads
    logic                     r1_valid;
    logic                     r1_sat;
    logic                     r1_neg;
    logic                     r1_mode;
    logic signed [GRAD_W-1:0] r1_grad;
    logic [SIG_W-1:0]         r1_lo;
    logic [SIG_W-1:0]         r1_diff;
    logic [FRAC_W-1:0]        r1_frac;
    // Stage 2: interpolated sigmoid
    logic                     r2_valid;
    logic                     r2_mode;
    logic signed [GRAD_W-1:0] r2_grad;
    logic [SIG_W-1:0]         r2_sig;
    // Stage 3: s*(1-s)
    logic                     r3_valid;
    logic                     r3_mode;
    logic signed [GRAD_W-1:0] r3_grad;
    logic [SIG_W-1:0]         r3_sig;
    logic [DS_W-1:0]          r3_ds;
    // Output
    logic                     r_valid;
    logic signed [VAL_W-1:0]  r_value;

    logic [ROM_AW-1:0]           lo_idx;
    logic [SIG_W-1:0]            tab_lo;
    logic [SIG_W-1:0]            tab_hi;
    logic [SIG_W-1:0]            n_diff;
    logic [SIG_W+FRAC_W-1:0]     interp;
    logic [SIG_W-1:0]            sig_abs;
    logic [SIG_W-1:0]            n_sig;
    logic [2*SIG_W-1:0]          ds_prod;
    logic [DS_W-1:0]             n_ds;
    logic signed [GRAD_W+DS_W:0] grad_prod;
    logic signed [GRAD_W+DS_W-12:0] grad_q;
    logic signed [VAL_W-1:0]     n_value;

    // The back end never stalls: take whatever the queue offers
    assign o_pop = i_valid;

    always_comb begin
        lo_idx  = ROM_AW'(i_item.seg);
        tab_lo  = SIG_ROM[lo_idx];
        tab_hi  = SIG_ROM[lo_idx + 1'b1];
        n_diff  = (tab_hi > tab_lo) ? tab_hi - tab_lo : '0;

        interp  = (SIG_W+FRAC_W)'(r1_diff) * (SIG_W+FRAC_W)'(r1_frac)
                  + (SIG_W+FRAC_W)'(1 << (FRAC_W - 1));
        sig_abs = r1_lo + interp[SIG_W+FRAC_W-1:FRAC_W];
        if (r1_sat) begin
            n_sig = '0;
        end else if (r1_neg) begin
            n_sig = SIG_W'(FIX_ONE) - sig_abs;
        end else begin
            n_sig = sig_abs;
        end

        ds_prod = (2*SIG_W)'(r2_sig) * (2*SIG_W)'(SIG_W'(FIX_ONE) - r2_sig)
                  + (2*SIG_W)'(FIX_ONE / 2);
        n_ds    = ds_prod[DS_W+11:12];

        grad_prod = (GRAD_W+DS_W+1)'(r3_grad) * (GRAD_W+DS_W+1)'($signed({1'b0, r3_ds}))
                    + (GRAD_W+DS_W+1)'(FIX_ONE / 2);
        grad_q    = grad_prod[GRAD_W+DS_W:12];
        if (r3_mode == MODE_FORWARD) begin
            n_value = VAL_W'(r3_sig);
        end else if (grad_q > (GRAD_W+DS_W-11)'(VAL_MAX)) begin
            n_value = VAL_W'(VAL_MAX);
        end else if (grad_q < (GRAD_W+DS_W-11)'(VAL_MIN)) begin
            n_value = VAL_W'(VAL_MIN);
        end else begin
            n_value = grad_q[VAL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r_valid  <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_sat  <= i_item.sat;
        r1_neg  <= i_item.neg;
        r1_mode <= i_item.mode;
        r1_grad <= i_item.grad;
        r1_lo   <= tab_lo;
        r1_diff <= n_diff;
        r1_frac <= i_item.frac;

        r2_mode <= r1_mode;
        r2_grad <= r1_grad;
        r2_sig  <= n_sig;

        r3_mode <= r2_mode;
        r3_grad <= r2_grad;
        r3_sig  <= r2_sig;
        r3_ds   <= n_ds;

        r_value <= n_value;
    end

    assign o_valid     = r_valid;
    assign o_value_out = r_value;

    a_sig_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r2_valid |-> r2_sig <= SIG_W'(FIX_ONE))
        else $error("sigmoid above one");

    a_fwd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r3_valid && r3_mode == MODE_FORWARD |=> r_value >= 0 && r_value <= VAL_W'(FIX_ONE))
        else $error("forward result outside 0..1");

    a_ds_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r3_valid |-> r3_ds <= DS_W'(FIX_ONE / 4))
        else $error("derivative above one quarter");

endmodule

// ===== rtl/sigmoid_activation_unit.sv =====
// Top level of the sigmoid activation unit: front end, decoupling queue and back end.
//
// Element-wise logistic sigmoid in Q4.12. Pulse start with an activation and a
// gradient while busy is low and the transaction is taken at that clock edge. In
// forward mode (pass_mode 0) the result is sigmoid(x), linearly interpolated in a
// constant table of TABLE_SEGMENTS+1 entries over 0..8 and mirrored for negative x;
// x = -8.0 gives exactly 0. In backward mode (pass_mode 1) the result is
// gradient * s * (1 - s), with s*(1-s) and the final product each rounded half up
// to Q4.12 and the result saturated to the 14-bit range. While busy is low the unit
// accepts one transaction every clock cycle; each result appears on o_value_out,
// marked by a one-cycle o_valid pulse, in order. On its way each transaction passes
// the front capture register, the queue slot and the four back-end stages (table
// read, interpolation multiply, s*(1-s) multiply, gradient multiply). The receiver
// cannot stall: the back end takes an element from the queue every cycle, so busy
// stays low in normal operation. Write pass_mode through i_cfg_we/i_cfg_wdata only
// while no transaction is in flight; each transaction takes the mode in force at its
// start edge. No clearing pass is needed after reset.
module sigmoid_activation_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_wdata,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [sau_pkg::ACT_W-1:0]  i_activation_in,
    input  logic signed [sau_pkg::GRAD_W-1:0] i_grad_in,
    output logic                              o_valid,
    output logic signed [sau_pkg::VAL_W-1:0]  o_value_out
);
    import sau_pkg::*;

    logic  queue_full;
    logic  push;
    t_item front_item;
    logic  queue_valid;
    t_item queue_item;
    logic  pop;

    // Capture and classify each transaction; hold it while the queue is full
    sau_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .start           (start),
        .busy            (busy),
        .i_activation_in (i_activation_in),
        .i_grad_in       (i_grad_in),
        .i_queue_full    (queue_full),
        .o_push          (push),
        .o_item          (front_item)
    );

    // Decouple the front end from the back end, which never stalls
    sau_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (queue_full),
        .i_pop   (pop),
        .o_valid (queue_valid),
        .o_item  (queue_item)
    );

    // Interpolate, mirror and, in backward mode, form the gradient product
    sau_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (queue_valid),
        .i_item      (queue_item),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .o_value_out (o_value_out)
    );

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("unit stalled although the back end never waits");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##6 o_valid)
        else $error("result strobe missing six cycles after start");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(pop, 4))
        else $error("result strobe without a queued transaction");

endmodule
